@@ hw/rtl/fdn_reverb_four_line_macros.svh @@
// Assertion helpers used by the RTL
`ifndef FDN_REVERB_FOUR_LINE_MACROS_SVH
`define FDN_REVERB_FOUR_LINE_MACROS_SVH

// same-cycle implication
`define FDN_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdn assertion failed");

// next-cycle implication
`define FDN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdn assertion failed");

`endif

@@ hw/rtl/fdn_pkg.sv @@
package fdn_pkg;

   localparam int NUM_LINES         = 4;
   localparam int DEF_MAX_DELAY     = 2048;
   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int DEF_STORE_WIDTH   = 24;
   localparam int OUT_WIDTH         = 24;
   localparam int GAIN_WIDTH        = 15;
   localparam int GAIN_SHIFT        = 15;
   localparam int LEN_WIDTH         = 12;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 16;

   localparam logic [GAIN_WIDTH-1:0] RST_GAIN = 15'd20850;
   localparam logic [NUM_LINES-1:0][LEN_WIDTH-1:0] RST_LEN =
      {12'd2000, 12'd600, 12'd400, 12'd222};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FEEDBACK_GAIN = 3'd0,
      CSR_DELAY_LEN_A   = 3'd1,
      CSR_DELAY_LEN_B   = 3'd2,
      CSR_DELAY_LEN_C   = 3'd3,
      CSR_DELAY_LEN_D   = 3'd4
   } csr_index_type;

   typedef logic signed [1:0] coef_type;
   localparam coef_type COEF_POS = 2'sb01;
   localparam coef_type COEF_NEG = 2'sb11;

   // orthogonal mixing matrix (rows of norm sqrt(2), not lossless), row k feeds line k
   localparam coef_type MIX_ROWS [NUM_LINES][NUM_LINES] = '{
      '{2'sb00, 2'sb01, 2'sb01, 2'sb00},
      '{2'sb11, 2'sb00, 2'sb00, 2'sb11},
      '{2'sb01, 2'sb00, 2'sb00, 2'sb11},
      '{2'sb00, 2'sb01, 2'sb11, 2'sb00}
   };

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

@@ hw/rtl/fdn_line_mem.sv @@
module fdn_line_mem import fdn_pkg::*; #(
   parameter int MAX_DELAY   = DEF_MAX_DELAY,
   parameter int STORE_WIDTH = DEF_STORE_WIDTH,
   localparam int AW = $clog2(MAX_DELAY)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mem_ctl_type                             ctl,
   input  logic [NUM_LINES-1:0][AW-1:0]            rd_addr,
   input  logic [NUM_LINES-1:0]                    rd_filled,
   input  logic [AW-1:0]                           wr_addr,
   input  logic [NUM_LINES-1:0][STORE_WIDTH-1:0]   wr_data,
   output logic [NUM_LINES-1:0][STORE_WIDTH-1:0]   rd_tap
);

   logic [NUM_LINES-1:0][STORE_WIDTH-1:0] rd_data_ff;
   logic [NUM_LINES-1:0][AW-1:0]          rd_addr_ff;
   logic [NUM_LINES-1:0]                  rd_filled_ff;
   logic                                  last_wr_valid_ff;
   logic [AW-1:0]                         last_wr_addr_ff;
   logic [NUM_LINES-1:0][STORE_WIDTH-1:0] last_wr_data_ff;

   for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
      logic [STORE_WIDTH-1:0] mem [MAX_DELAY];

      always_ff @(posedge clock) begin
         if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data[k];
         end
         if (ctl.rd_en) begin
            rd_data_ff[k] <= mem[rd_addr[k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_addr_ff   <= rd_addr;
         rd_filled_ff <= rd_filled;
      end
      if (ctl.wr_en) begin
         last_wr_addr_ff <= wr_addr;
         last_wr_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else if (ctl.wr_en) begin
         last_wr_valid_ff <= 1'b1;
      end
   end

   // newest write wins over the (possibly stale) array read; unwritten slots read zero
   always_comb begin
      for (int k = 0; k < NUM_LINES; k++) begin
         if (last_wr_valid_ff && (last_wr_addr_ff == rd_addr_ff[k])) begin
            rd_tap[k] = last_wr_data_ff[k];
         end else if (rd_filled_ff[k]) begin
            rd_tap[k] = rd_data_ff[k];
         end else begin
            rd_tap[k] = '0;
         end
      end
   end

endmodule

@@ hw/rtl/fdn_reverb_four_line.sv @@
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_ready  | req_sample_in  (signed SAMPLE_WIDTH)
// rsp     | out | rsp_valid / rsp_ready  | rsp_sample_out (signed 24)
// csr     | in  | csr_valid / csr_ready  | csr_index (3), csr_wdata (16)
//
// One beat per cycle sustained while rsp_ready stays high; acceptance registers the tap
// reads and sample into s1; when s1 advances, it mixes, writes back and loads rsp.
// Mix, gain and write-back are combinational from s1 and the store bypasses the newest
// write, so a delay of one sample chains. A wrap flag on the write pointer makes unwritten
// slots read zero, so the line stores get no clearing pass.
// A stalled rsp holds a full mix stage and drops req_ready; csr_ready is always high.
`include "fdn_reverb_four_line_macros.svh"

module fdn_reverb_four_line import fdn_pkg::*; #(
   parameter int MAX_DELAY    = DEF_MAX_DELAY,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int STORE_WIDTH  = DEF_STORE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [OUT_WIDTH-1:0]       rsp_sample_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_wdata
);

   localparam int AW  = $clog2(MAX_DELAY);
   localparam int LW  = $clog2(MAX_DELAY + 1);
   localparam int CW  = (LW > LEN_WIDTH) ? LW : LEN_WIDTH;
   localparam int SW  = STORE_WIDTH;
   localparam int MW0 = (SW > SAMPLE_WIDTH) ? SW : SAMPLE_WIDTH;
   localparam int MW1 = (MW0 > OUT_WIDTH) ? MW0 : OUT_WIDTH;
   localparam int YW  = MW1 + 3;
   localparam int RW  = SW + 2;
   localparam int PW  = RW + GAIN_WIDTH + 1;
   localparam int EW  = PW + 1;

   localparam logic signed [YW-1:0] Y_HI =
      {{(YW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [YW-1:0] Y_LO = ~Y_HI;
   localparam logic signed [EW-1:0] S_HI = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [EW-1:0] S_LO = ~S_HI;
   localparam logic [AW-1:0]        WP_LAST = AW'(MAX_DELAY - 1);

   function automatic logic [LW-1:0] clamp_len(input logic [LEN_WIDTH-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w == '0) begin
         w = CW'(1);
      end else if (w > CW'(MAX_DELAY)) begin
         w = CW'(MAX_DELAY);
      end
      return w[LW-1:0];
   endfunction

   logic [GAIN_WIDTH-1:0]               gain_ff, gain_in;
   logic [NUM_LINES-1:0][LW-1:0]        len_ff, len_in;
   logic [AW-1:0]                       wp_ff, wp_in;
   logic                                wrap_ff, wrap_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]      s1_x_ff;
   logic [AW-1:0]                       s1_wp_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]         rsp_data_ff;

   logic                                req_acc;
   logic                                s1_adv;
   mem_ctl_type                         mem_ctl;
   logic [NUM_LINES-1:0][AW-1:0]        rd_addr;
   logic [NUM_LINES-1:0]                rd_filled;
   logic [NUM_LINES-1:0][SW-1:0]        rd_tap;
   logic [NUM_LINES-1:0][SW-1:0]        wr_data;
   logic signed [OUT_WIDTH-1:0]         y_sat;

   assign csr_ready      = 1'b1;
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !s1_valid_ff || s1_adv;
   assign req_acc        = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign mem_ctl.rd_en  = req_acc;
   assign mem_ctl.wr_en  = s1_adv;

   always_comb begin
      gain_in = gain_ff;
      len_in  = len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FEEDBACK_GAIN: gain_in   = csr_wdata[GAIN_WIDTH-1:0];
            CSR_DELAY_LEN_A:   len_in[0] = clamp_len(csr_wdata[LEN_WIDTH-1:0]);
            CSR_DELAY_LEN_B:   len_in[1] = clamp_len(csr_wdata[LEN_WIDTH-1:0]);
            CSR_DELAY_LEN_C:   len_in[2] = clamp_len(csr_wdata[LEN_WIDTH-1:0]);
            CSR_DELAY_LEN_D:   len_in[3] = clamp_len(csr_wdata[LEN_WIDTH-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [LW:0] wpx;
      logic [LW:0] lx;
      logic [LW:0] d;
      for (int k = 0; k < NUM_LINES; k++) begin
         wpx = (LW+1)'(wp_ff);
         lx  = (LW+1)'(len_ff[k]);
         if (wpx >= lx) begin
            d = wpx - lx;
         end else begin
            d = wpx + (LW+1)'(MAX_DELAY) - lx;
         end
         rd_addr[k]   = d[AW-1:0];
         rd_filled[k] = wrap_ff || (d[AW-1:0] < wp_ff);
      end
   end

   always_comb begin
      wp_in   = wp_ff;
      wrap_in = wrap_ff;
      if (req_acc) begin
         if (wp_ff == WP_LAST) begin
            wp_in   = '0;
            wrap_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   fdn_line_mem #(
      .MAX_DELAY   (MAX_DELAY),
      .STORE_WIDTH (STORE_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mem_ctl),
      .rd_addr   (rd_addr),
      .rd_filled (rd_filled),
      .wr_addr   (s1_wp_ff),
      .wr_data   (wr_data),
      .rd_tap    (rd_tap)
   );

   // output sum saturated; per-line feedback: mix, gain, floor shift, add sample, saturate
   always_comb begin
      logic signed [YW-1:0] y_sum;
      logic signed [RW-1:0] t;
      logic signed [RW-1:0] r;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] sh;
      logic signed [EW-1:0] e;
      y_sum = YW'(s1_x_ff);
      for (int k = 0; k < NUM_LINES; k++) begin
         y_sum = y_sum + YW'($signed(rd_tap[k]));
      end
      if (y_sum > Y_HI) begin
         y_sum = Y_HI;
      end else if (y_sum < Y_LO) begin
         y_sum = Y_LO;
      end
      y_sat = y_sum[OUT_WIDTH-1:0];
      for (int k = 0; k < NUM_LINES; k++) begin
         r = '0;
         for (int j = 0; j < NUM_LINES; j++) begin
            t = RW'($signed(rd_tap[j]));
            case (MIX_ROWS[k][j])
               COEF_POS: r = r + t;
               COEF_NEG: r = r - t;
               default: ;
            endcase
         end
         prod = PW'(r) * $signed({{(PW-GAIN_WIDTH){1'b0}}, gain_ff});
         sh   = prod >>> GAIN_SHIFT;
         e    = EW'(sh) + EW'(s1_x_ff);
         if (e > S_HI) begin
            e = S_HI;
         end else if (e < S_LO) begin
            e = S_LO;
         end
         wr_data[k] = e[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= RST_GAIN;
         for (int k = 0; k < NUM_LINES; k++) begin
            len_ff[k] <= clamp_len(RST_LEN[k]);
         end
         wp_ff        <= '0;
         wrap_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         wrap_ff      <= wrap_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_x_ff  <= req_sample_in;
         s1_wp_ff <= wp_ff;
      end
      if (s1_adv) begin
         rsp_data_ff <= y_sat;
      end
   end

   `FDN_ASSERT_NEXT(a_wp_step, (req_acc && (wp_ff != WP_LAST)),
                    (wp_ff == $past(wp_ff) + AW'(1)))
   `FDN_ASSERT_NEXT(a_wrap_sticky, wrap_ff, wrap_ff)
   `FDN_ASSERT_NEXT(a_s1_hold, (s1_valid_ff && !s1_adv),
                    (s1_valid_ff && $stable(s1_wp_ff) && $stable(s1_x_ff)))
   `FDN_ASSERT_NEXT(a_wb_to_rsp, s1_adv, rsp_valid_ff)

endmodule
